>>> rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants for the shell word splitter
// Beat formats for the byte channel and the result channel, character codes
// and the one-hot scan mode encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sws_pkg;

  // Characters with a special meaning to the splitter.
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;

  // Most results that a single input byte can give.
  localparam int unsigned MaxResults = 3;

  typedef enum logic [4:0] {
    MODE_BETWEEN = 5'b00001,
    MODE_PLAIN   = 5'b00010,
    MODE_DQ      = 5'b00100,
    MODE_SQ      = 5'b01000,
    MODE_COMMENT = 5'b10000
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in_line;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       word_end;
    logic       line_end;
    logic       last_of_run;
  } out_beat_t;

endpackage

>>> rtl/shell_word_splitter.sv
// ----------------------------------------------------------------------------
// shell_word_splitter: byte-serial shell-style word splitter
// The first result of an accepted byte is offered in the cycle after the byte is taken.
// One byte per cycle while each byte gives at most one result and the result
// port is not stalled; the results of a byte giving more (up to three) are
// drained one beat at a time by the single result port from the result buffer.
// Reset clears the scan mode, the held backslash and the result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shell_word_splitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sws_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sws_pkg::out_beat_t out_beat_o
);

  import sws_pkg::*;

  // Scanner state: where we are in the line, and whether a backslash inside
  // a word is waiting to see the following byte before it is given or dropped.
  scan_mode_e mode_q, mode_d;
  logic       held_q, held_d;

  // Result buffer. Entry 0 is always the beat on offer; the buffer shifts
  // down by one entry each time a result beat is taken.
  out_beat_t  buf_q [MaxResults];
  out_beat_t  buf_d [MaxResults];
  logic [1:0] cnt_q, cnt_d;

  // Results computed for the byte now on the input.
  out_beat_t  res   [MaxResults];
  logic [1:0] res_n;

  logic in_fire;
  logic out_fire;

  logic [7:0] b;
  logic       last;
  logic       is_space;
  logic       is_escapable;
  logic       is_quote;

  function automatic out_beat_t make_res(logic [7:0] byte_v, logic valid_v,
                                         logic we_v, logic le_v);
    out_beat_t r;
    r.out_byte    = byte_v;
    r.byte_valid  = valid_v;
    r.word_end    = we_v;
    r.line_end    = le_v;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign b    = in_beat_i.char_in;
  assign last = in_beat_i.last_in_line;

  // Whitespace is space and the control range from tab to carriage return.
  assign is_space     = (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  assign is_escapable = (b == ChDquote) || (b == ChSquote) || (b == ChHash);
  assign is_quote     = (b == ChDquote) || (b == ChSquote);

  // A new byte is taken when the buffer is empty, or when its only remaining
  // beat leaves in this same cycle: unstalled, one-result bytes flow every cycle.
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_beat_o  = buf_q[0];
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i));
  assign in_fire     = in_valid_i && !in_stall_o;

  // Scanner: works out the results of one byte and the state that it leaves.
  always_comb begin
    logic do_word;

    do_word = 1'b0;
    mode_d  = mode_q;
    held_d  = held_q;
    res_n   = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end

    case (mode_q)
      MODE_PLAIN: begin
        if (is_space) begin
          // A backslash that ends a word at whitespace is kept.
          if (held_q) begin
            res[res_n] = make_res(ChBackslash, 1'b1, 1'b0, 1'b0);
            res_n      = res_n + 2'd1;
          end
          held_d     = 1'b0;
          res[res_n] = make_res(8'h00, 1'b0, 1'b1, last);
          res_n      = res_n + 2'd1;
          mode_d     = MODE_BETWEEN;
        end else begin
          do_word = 1'b1;
        end
      end
      MODE_DQ, MODE_SQ: begin
        // The closing quote must match the opening one and not be escaped.
        if (!held_q && (((mode_q == MODE_DQ) && (b == ChDquote)) ||
                        ((mode_q == MODE_SQ) && (b == ChSquote)))) begin
          res[res_n] = make_res(8'h00, 1'b0, 1'b1, last);
          res_n      = res_n + 2'd1;
          mode_d     = MODE_BETWEEN;
        end else begin
          do_word = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (last) begin
          res[res_n] = make_res(8'h00, 1'b0, 1'b0, 1'b1);
          res_n      = res_n + 2'd1;
        end
      end
      default: begin
        // Between words.
        held_d = 1'b0;
        if (is_space) begin
          if (last) begin
            res[res_n] = make_res(8'h00, 1'b0, 1'b0, 1'b1);
            res_n      = res_n + 2'd1;
          end
          mode_d = MODE_BETWEEN;
        end else if (b == ChHash) begin
          if (last) begin
            res[res_n] = make_res(8'h00, 1'b0, 1'b0, 1'b1);
            res_n      = res_n + 2'd1;
          end else begin
            mode_d = MODE_COMMENT;
          end
        end else if (is_quote) begin
          // A lone quote on the last byte becomes a word of its own.
          if (last) begin
            res[res_n] = make_res(b, 1'b1, 1'b0, 1'b0);
            res_n      = res_n + 2'd1;
            res[res_n] = make_res(8'h00, 1'b0, 1'b1, 1'b1);
            res_n      = res_n + 2'd1;
          end else begin
            mode_d = (b == ChDquote) ? MODE_DQ : MODE_SQ;
          end
        end else begin
          mode_d  = MODE_PLAIN;
          do_word = 1'b1;
        end
      end
    endcase

    // Content byte of a word, plain or quoted.
    if (do_word) begin
      if (held_d) begin
        // The held backslash is dropped before a quote or hash only.
        if (!is_escapable) begin
          res[res_n] = make_res(ChBackslash, 1'b1, 1'b0, 1'b0);
          res_n      = res_n + 2'd1;
        end
        held_d = 1'b0;
      end
      if ((b == ChBackslash) && !last) begin
        held_d = 1'b1;
      end else begin
        res[res_n] = make_res(b, 1'b1, 1'b0, 1'b0);
        res_n      = res_n + 2'd1;
      end
      if (last) begin
        res[res_n] = make_res(8'h00, 1'b0, 1'b1, 1'b1);
        res_n      = res_n + 2'd1;
      end
    end

    // The end of the line returns the scanner to its reset state.
    if (last) begin
      mode_d = MODE_BETWEEN;
      held_d = 1'b0;
    end

    if (res_n != 2'd0) begin
      res[res_n - 2'd1].last_of_run = 1'b1;
    end
  end

  // Result buffer: loaded with a whole byte's results, drained one beat at a
  // time. A load only happens once the buffer is, or is about to be, empty.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxResults; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (in_fire) begin
      cnt_d = res_n;
      for (int i = 0; i < MaxResults; i++) begin
        buf_d[i] = res[i];
      end
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN;
      held_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        mode_q <= mode_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  // A byte is only taken when the buffer has room for all of its results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire)))
    else $error("byte accepted while earlier results were still buffered");

  // The buffer holds exactly the results of the byte just taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (cnt_q == $past(res_n)))
    else $error("result count does not match the accepted byte");

  // The last beat leaving the buffer is the final result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cnt_q == 2'd1)) |-> out_beat_o.last_of_run)
    else $error("final buffered beat lacks its last-of-run mark");

  // A backslash can only be held inside a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> ((mode_q == MODE_PLAIN) || (mode_q == MODE_DQ) || (mode_q == MODE_SQ)))
    else $error("backslash held outside a word");

  // The last byte of a line leaves the scanner in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_beat_i.last_in_line) |=> ((mode_q == MODE_BETWEEN) && !held_q))
    else $error("scanner not back between words after the line end");

endmodule
